FILE: hdl/m3i_pkg.sv
`default_nettype none
package m3i_pkg;
    localparam int unsigned DIM   = 3;
    localparam int unsigned LANES = DIM * DIM;

    typedef struct packed {
        logic valid;
        logic singular;
    } m3i_ctrl_t;
endpackage
`default_nettype wire

FILE: hdl/m3i_cofactor.sv
`default_nettype none
module m3i_cofactor #(
    parameter int W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  a [0:m3i_pkg::DIM-1][0:m3i_pkg::DIM-1],
    output logic                 out_valid,
    output logic signed [2*W:0]  cof [0:m3i_pkg::DIM-1][0:m3i_pkg::DIM-1],
    output logic signed [W-1:0]  col0 [0:m3i_pkg::DIM-1]
);
    import m3i_pkg::*;

    logic signed [2*W-1:0] pt_reg [0:DIM-1][0:DIM-1];
    logic signed [2*W-1:0] pu_reg [0:DIM-1][0:DIM-1];
    logic signed [W-1:0]   c0_s1_reg [0:DIM-1];
    logic signed [2*W:0]   cof_reg [0:DIM-1][0:DIM-1];
    logic signed [W-1:0]   c0_s2_reg [0:DIM-1];
    logic                  v1_reg;
    logic                  v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // The cyclic index form gives each minor its checkerboard sign directly.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < DIM; r++)
        begin
            c0_s1_reg[r] <= a[r][0];
            c0_s2_reg[r] <= c0_s1_reg[r];
            for (int c = 0; c < DIM; c++)
            begin
                pt_reg[r][c]  <= a[(r+1)%DIM][(c+1)%DIM] * a[(r+2)%DIM][(c+2)%DIM];
                pu_reg[r][c]  <= a[(r+1)%DIM][(c+2)%DIM] * a[(r+2)%DIM][(c+1)%DIM];
                cof_reg[r][c] <= (2*W+1)'(pt_reg[r][c]) - (2*W+1)'(pu_reg[r][c]);
            end
        end
    end

    assign out_valid = v2_reg;
    assign cof       = cof_reg;
    assign col0      = c0_s2_reg;
endmodule
`default_nettype wire

FILE: hdl/m3i_det.sv
`default_nettype none
module m3i_det #(
    parameter int W = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic signed [2*W:0]    cof_in [0:m3i_pkg::DIM-1][0:m3i_pkg::DIM-1],
    input  logic signed [W-1:0]    col0 [0:m3i_pkg::DIM-1],
    output logic                   out_valid,
    output logic signed [3*W+2:0]  det,
    output logic signed [2*W:0]    cof_out [0:m3i_pkg::DIM-1][0:m3i_pkg::DIM-1]
);
    import m3i_pkg::*;

    localparam int DW = 3 * W + 3;

    logic signed [2*W:0]  plo_reg [0:DIM-1];
    logic signed [2*W:0]  phi_reg [0:DIM-1];
    logic signed [2*W:0]  cof_s3_reg [0:DIM-1][0:DIM-1];
    logic signed [2*W:0]  cof_s4_reg [0:DIM-1][0:DIM-1];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;
    logic                 v3_reg;
    logic                 v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    // The cofactor is split in halves so that each product stays near W by W bits.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < DIM; r++)
        begin
            plo_reg[r] <= col0[r] * $signed({1'b0, cof_in[r][0][W-1:0]});
            phi_reg[r] <= col0[r] * $signed(cof_in[r][0][2*W:W]);
        end
        cof_s3_reg <= cof_in;
        cof_s4_reg <= cof_s3_reg;
        det_reg    <= det_next;
    end

    always_comb
    begin
        det_next = '0;
        for (int r = 0; r < DIM; r++)
        begin
            det_next = det_next + (DW'(phi_reg[r]) <<< W) + DW'(plo_reg[r]);
        end
    end

    assign out_valid = v4_reg;
    assign det       = det_reg;
    assign cof_out   = cof_s4_reg;
endmodule
`default_nettype wire

FILE: hdl/m3i_div.sv
`default_nettype none
module m3i_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [3*W+2:0] det,
    input  logic signed [2*W:0]   cof [0:m3i_pkg::DIM-1][0:m3i_pkg::DIM-1],
    output m3i_pkg::m3i_ctrl_t    out_ctrl,
    output logic signed [W-1:0]   inv [0:m3i_pkg::LANES-1],
    output logic signed [W-1:0]   det_value
);
    import m3i_pkg::*;

    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int NA = 2 * W + 2 * F + 2;
    localparam int NW = ((NA > DW) ? NA : DW) + 1;
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};

    // First preparation stage: magnitudes and signs.
    logic [CW-1:0] an_reg [0:LANES-1];
    logic          sn_reg [0:LANES-1];
    logic [DW-1:0] ad_reg;
    logic          sd_reg;
    logic          zero_reg;
    logic          vp_reg;

    // Divider pipeline, index 0 is the second preparation stage.
    logic [DW:0]   rem_reg  [0:W][0:LANES-1];
    logic [W-1:0]  nlo_reg  [0:W][0:LANES-1];
    logic [W-1:0]  q_reg    [0:W][0:LANES-1];
    logic          neg_reg  [0:W][0:LANES-1];
    logic          ovf_reg  [0:W][0:LANES-1];
    logic [DW:0]   dd_reg   [0:W];
    logic [DW:0]   dq_reg   [0:W];
    logic          dneg_reg [0:W];
    logic          sing_reg [0:W];
    logic          v_reg    [0:W];

    logic [NW-1:0] num      [0:LANES-1];
    logic [DW:0]   rem_next [0:W-1][0:LANES-1];
    logic          ge       [0:W-1][0:LANES-1];

    logic signed [W-1:0] inv_reg [0:LANES-1];
    logic signed [W-1:0] inv_next [0:LANES-1];
    logic signed [W-1:0] dv_reg;
    logic signed [W-1:0] dv_next;
    m3i_ctrl_t           ctrl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg   <= 1'b0;
            ctrl_reg <= '0;
            for (int s = 0; s <= W; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vp_reg <= in_valid;
            v_reg[0] <= vp_reg;
            for (int s = 0; s < W; s++)
            begin
                v_reg[s+1] <= v_reg[s];
            end
            ctrl_reg.valid    <= v_reg[W];
            ctrl_reg.singular <= v_reg[W] & sing_reg[W];
        end
    end

    // Rounded numerator 2|n|*2^2F + |d| over denominator 2|d| gives the
    // nearest quotient with halves away from zero.
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            num[k] = (NW'(an_reg[k]) << (2*F+1)) + NW'(ad_reg);
        end
    end

    always_comb
    begin
        for (int s = 0; s < W; s++)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                ge[s][k] = {rem_reg[s][k], nlo_reg[s][k][W-1]} >= {1'b0, dd_reg[s]};
                rem_next[s][k] = ge[s][k]
                    ? (DW+1)'({rem_reg[s][k], nlo_reg[s][k][W-1]} - {1'b0, dd_reg[s]})
                    : (DW+1)'({rem_reg[s][k], nlo_reg[s][k][W-1]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < DIM; c++)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                sn_reg[c*DIM+r] <= cof[c][r][CW-1];
                an_reg[c*DIM+r] <= cof[c][r][CW-1] ? $unsigned(-cof[c][r])
                                                   : $unsigned(cof[c][r]);
            end
        end
        sd_reg   <= det[DW-1];
        ad_reg   <= det[DW-1] ? $unsigned(-det) : $unsigned(det);
        zero_reg <= (det == '0);

        for (int k = 0; k < LANES; k++)
        begin
            ovf_reg[0][k] <= (num[k] >> W) >= (NW'(ad_reg) << 1);
            rem_reg[0][k] <= (DW+1)'(num[k] >> W);
            nlo_reg[0][k] <= num[k][W-1:0];
            q_reg[0][k]   <= '0;
            neg_reg[0][k] <= sn_reg[k] ^ sd_reg;
        end
        dd_reg[0]   <= {ad_reg, 1'b0};
        dq_reg[0]   <= ((DW+1)'(ad_reg) + ((DW+1)'(1) << (2*F-1))) >> (2*F);
        dneg_reg[0] <= sd_reg;
        sing_reg[0] <= zero_reg;

        for (int s = 0; s < W; s++)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                rem_reg[s+1][k] <= rem_next[s][k];
                nlo_reg[s+1][k] <= nlo_reg[s][k] << 1;
                q_reg[s+1][k]   <= {q_reg[s][k][W-2:0], ge[s][k]};
                neg_reg[s+1][k] <= neg_reg[s][k];
                ovf_reg[s+1][k] <= ovf_reg[s][k];
            end
            dd_reg[s+1]   <= dd_reg[s];
            dq_reg[s+1]   <= dq_reg[s];
            dneg_reg[s+1] <= dneg_reg[s];
            sing_reg[s+1] <= sing_reg[s];
        end

        inv_reg <= inv_next;
        dv_reg  <= dv_next;
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (sing_reg[W])
            begin
                inv_next[k] = '0;
            end
            else if (ovf_reg[W][k])
            begin
                inv_next[k] = neg_reg[W][k] ? $signed(HALF) : $signed(MAXP);
            end
            else if (neg_reg[W][k])
            begin
                inv_next[k] = (q_reg[W][k] > HALF) ? $signed(HALF)
                                                   : $signed(W'(0) - q_reg[W][k]);
            end
            else
            begin
                inv_next[k] = (q_reg[W][k] > MAXP) ? $signed(MAXP) : $signed(q_reg[W][k]);
            end
        end

        if (sing_reg[W])
        begin
            dv_next = '0;
        end
        else if (dneg_reg[W])
        begin
            dv_next = (dq_reg[W] > (DW+1)'(HALF)) ? $signed(HALF)
                                                  : $signed(W'((DW+1)'(0) - dq_reg[W]));
        end
        else
        begin
            dv_next = (dq_reg[W] > (DW+1)'(MAXP)) ? $signed(MAXP) : $signed(W'(dq_reg[W]));
        end
    end

    assign out_ctrl  = ctrl_reg;
    assign inv       = inv_reg;
    assign det_value = dv_reg;
endmodule
`default_nettype wire

FILE: hdl/matrix3_inverse.sv
`default_nettype none
// Inverse of a 3x3 signed fixed-point matrix by the adjugate method. A matrix is taken
// on every clock at which start is high (busy never rises), and its result appears as
// a one-cycle done strobe with the nine inverse elements, the determinant and the
// singular flag; the receiver cannot hold results off, so it must take each beat
// on the cycle it is shown. The latency is set mainly by the quotient pipeline, which
// retires one quotient bit per stage for all nine elements side by side. Results are
// rounded to nearest, halves away from zero, and saturated; a zero determinant raises
// singular and zeroes every other output.
module matrix3_inverse #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c2,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c2,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c2,
    output logic                         done,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c0,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c1,
    output logic signed [ELEM_WIDTH-1:0] inv_r0c2,
    output logic signed [ELEM_WIDTH-1:0] inv_r1c2,
    output logic signed [ELEM_WIDTH-1:0] inv_r2c2,
    output logic signed [ELEM_WIDTH-1:0] det_value,
    output logic                         singular
);
    import m3i_pkg::*;

    localparam int W = ELEM_WIDTH;

    logic signed [W-1:0]   mat [0:DIM-1][0:DIM-1];
    logic                  cof_valid;
    logic signed [2*W:0]   cof [0:DIM-1][0:DIM-1];
    logic signed [W-1:0]   col0 [0:DIM-1];
    logic                  det_valid;
    logic signed [3*W+2:0] det;
    logic signed [2*W:0]   cof_d [0:DIM-1][0:DIM-1];
    m3i_ctrl_t             ctrl;
    logic signed [W-1:0]   inv [0:LANES-1];
    logic                  accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign mat[0][0] = in_r0c0;
    assign mat[1][0] = in_r1c0;
    assign mat[2][0] = in_r2c0;
    assign mat[0][1] = in_r0c1;
    assign mat[1][1] = in_r1c1;
    assign mat[2][1] = in_r2c1;
    assign mat[0][2] = in_r0c2;
    assign mat[1][2] = in_r1c2;
    assign mat[2][2] = in_r2c2;

    m3i_cofactor #(.W(W)) u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .a         (mat),
        .out_valid (cof_valid),
        .cof       (cof),
        .col0      (col0)
    );

    m3i_det #(.W(W)) u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cof_valid),
        .cof_in    (cof),
        .col0      (col0),
        .out_valid (det_valid),
        .det       (det),
        .cof_out   (cof_d)
    );

    m3i_div #(.W(W), .F(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (det_valid),
        .det       (det),
        .cof       (cof_d),
        .out_ctrl  (ctrl),
        .inv       (inv),
        .det_value (det_value)
    );

    assign done     = ctrl.valid;
    assign singular = ctrl.singular;
    assign inv_r0c0 = inv[0];
    assign inv_r1c0 = inv[1];
    assign inv_r2c0 = inv[2];
    assign inv_r0c1 = inv[3];
    assign inv_r1c1 = inv[4];
    assign inv_r2c1 = inv[5];
    assign inv_r0c2 = inv[6];
    assign inv_r1c2 = inv[7];
    assign inv_r2c2 = inv[8];
endmodule
`default_nettype wire

FILE: hdl/m3i_checker.sv
`default_nettype none
module m3i_checker #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  done,
    input  logic                  singular,
    input  logic [ELEM_WIDTH-1:0] det_value,
    input  logic [ELEM_WIDTH-1:0] inv_r0c0,
    input  logic [ELEM_WIDTH-1:0] inv_r1c1,
    input  logic [ELEM_WIDTH-1:0] inv_r2c2
);
    localparam int LAT = ELEM_WIDTH + 7;

    // Every accepted beat comes out a fixed number of cycles later, and only then.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##LAT done)
        else $error("result missing after accepted beat");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(start, LAT))
        else $error("result without matching input beat");

    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a streaming block");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (det_value == '0 && inv_r0c0 == '0 &&
                                inv_r1c1 == '0 && inv_r2c2 == '0))
        else $error("singular result carries nonzero values");
endmodule

bind matrix3_inverse m3i_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_m3i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .singular  (singular),
    .det_value (det_value),
    .inv_r0c0  (inv_r0c0),
    .inv_r1c1  (inv_r1c1),
    .inv_r2c2  (inv_r2c2)
);
`default_nettype wire
